### rtl/octree_point_locate_defines.svh
// ----------------------------------------------------------------------------
// Octree point locate assertion macros
// Shared concurrent-assertion shorthands, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef OCTREE_POINT_LOCATE_DEFINES_SVH
`define OCTREE_POINT_LOCATE_DEFINES_SVH

// Same-cycle implication
`define OPL_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define OPL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/opl_pkg.sv
// ----------------------------------------------------------------------------
// Octree point locate package
// Field widths and request codes shared by the octree locate block.
// ----------------------------------------------------------------------------
package opl_pkg;

   localparam int PosW  = 10;
   localparam int IdxW  = 10;
   localparam int WordW = 32;
   localparam int ValW  = 31;
   localparam int CellW = 11;
   localparam int LvlW  = 4;
   localparam int LeafBit = 31;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_LOCATE = 1'b1
   } op_type;

endpackage

### rtl/opl_ram.sv
// ----------------------------------------------------------------------------
// Octree point locate RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module opl_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/octree_point_locate.sv
// ----------------------------------------------------------------------------
// Octree point locate
// Stores an octree as a table of node words and walks it for a query point,
// one level per table read, returning the cell that holds the point.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | op, table_index, table_word, pos_x/y/z
//   rsp     | out       | rsp_valid/rsp_stall | leaf_value, is_leaf, index_error,
//           |           |                     | cell_size, box_min_x/y/z, level
//
// A table write gives no response. A query reads the table once for the root
// and once per level descended (at most LEVELS), through the single table read port.
// One request is in work at a time; req_stall is high while a query walks or
// its finished response waits for the output register to free up.
// A finished response waits in the output register; a new request is taken
// meanwhile. Reset is synchronous; table contents are undefined until written.
// ----------------------------------------------------------------------------
`include "octree_point_locate_defines.svh"

module octree_point_locate #(
   parameter int LEVELS      = 10,
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_op,
   input  logic [opl_pkg::IdxW-1:0]    req_table_index,
   input  logic [opl_pkg::WordW-1:0]   req_table_word,
   input  logic [opl_pkg::PosW-1:0]    req_pos_x,
   input  logic [opl_pkg::PosW-1:0]    req_pos_y,
   input  logic [opl_pkg::PosW-1:0]    req_pos_z,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [opl_pkg::ValW-1:0]    rsp_leaf_value,
   output logic                        rsp_is_leaf,
   output logic                        rsp_index_error,
   output logic [opl_pkg::CellW-1:0]   rsp_cell_size,
   output logic [opl_pkg::PosW-1:0]    rsp_box_min_x,
   output logic [opl_pkg::PosW-1:0]    rsp_box_min_y,
   output logic [opl_pkg::PosW-1:0]    rsp_box_min_z,
   output logic [opl_pkg::LvlW-1:0]    rsp_level
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int LW = LEVELS;
   localparam int SW = LEVELS + 1;
   localparam int DW = $clog2(LEVELS + 1);
   localparam logic [opl_pkg::LvlW-1:0] LvlBottom = opl_pkg::LvlW'(LEVELS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [LW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [SW-1:0] size_ff, size_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [opl_pkg::PosW-1:0] min_x_ff, min_x_in, min_y_ff, min_y_in, min_z_ff, min_z_in;
   logic [opl_pkg::WordW-1:0] node_ff, node_in;
   logic err_ff, err_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [opl_pkg::ValW-1:0]   rsp_leaf_value_ff, rsp_leaf_value_in;
   logic                       rsp_is_leaf_ff, rsp_is_leaf_in;
   logic                       rsp_index_error_ff, rsp_index_error_in;
   logic [opl_pkg::CellW-1:0]  rsp_cell_size_ff, rsp_cell_size_in;
   logic [opl_pkg::PosW-1:0]   rsp_box_min_x_ff, rsp_box_min_x_in;
   logic [opl_pkg::PosW-1:0]   rsp_box_min_y_ff, rsp_box_min_y_in;
   logic [opl_pkg::PosW-1:0]   rsp_box_min_z_ff, rsp_box_min_z_in;
   logic [opl_pkg::LvlW-1:0]   rsp_level_ff, rsp_level_in;

   logic                       ram_wr_en;
   logic                       ram_rd_en;
   logic [AW-1:0]              ram_rd_addr;
   logic [opl_pkg::WordW-1:0]  ram_rd_data;

   logic                       out_free;
   logic                       wr_in_range;
   logic [opl_pkg::WordW-1:0]  node;
   logic                       bx, by, bz;
   logic [opl_pkg::WordW-1:0]  child_idx;
   logic                       child_bad;
   logic [SW-1:0]              half;
   logic                       at_bottom;

   logic                       query_take;
   logic                       write_quiet;
   logic                       walking;
   logic [SW-1:0]              size_want;
   logic                       inner_done;

   opl_ram #(
      .Width (opl_pkg::WordW),
      .Depth (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (AW'(req_table_index)),
      .wr_data (req_table_word),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign wr_in_range = (32'(req_table_index) < 32'(TABLE_DEPTH));

   assign node      = ram_rd_data;
   assign bx        = x_ff[LW-1];
   assign by        = y_ff[LW-1];
   assign bz        = z_ff[LW-1];
   assign child_idx = {1'b0, node[opl_pkg::ValW-1:0]} + {29'b0, bz, by, bx};
   assign child_bad = (child_idx >= 32'(TABLE_DEPTH));
   assign half      = size_ff >> 1;
   assign at_bottom = (depth_ff == DW'(LEVELS));

   always_comb begin
      state_in    = state_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      z_in        = z_ff;
      size_in     = size_ff;
      depth_in    = depth_ff;
      min_x_in    = min_x_ff;
      min_y_in    = min_y_ff;
      min_z_in    = min_z_ff;
      node_in     = node_ff;
      err_in      = err_ff;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;

      // drop the response once taken
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_leaf_value_in  = rsp_leaf_value_ff;
      rsp_is_leaf_in     = rsp_is_leaf_ff;
      rsp_index_error_in = rsp_index_error_ff;
      rsp_cell_size_in   = rsp_cell_size_ff;
      rsp_box_min_x_in   = rsp_box_min_x_ff;
      rsp_box_min_y_in   = rsp_box_min_y_ff;
      rsp_box_min_z_in   = rsp_box_min_z_ff;
      rsp_level_in       = rsp_level_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == opl_pkg::OP_WRITE) begin
                  ram_wr_en = wr_in_range;
               end else begin
                  // fetch the root word
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = '0;
                  x_in        = LW'(req_pos_x);
                  y_in        = LW'(req_pos_y);
                  z_in        = LW'(req_pos_z);
                  size_in     = SW'(1) << LEVELS;
                  depth_in    = '0;
                  min_x_in    = '0;
                  min_y_in    = '0;
                  min_z_in    = '0;
                  state_in    = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (node[opl_pkg::LeafBit] || at_bottom || child_bad) begin
               err_in  = !node[opl_pkg::LeafBit] && !at_bottom;
               node_in = node;
               if (out_free) begin
                  rsp_valid_in       = 1'b1;
                  rsp_leaf_value_in  = node[opl_pkg::ValW-1:0];
                  rsp_is_leaf_in     = node[opl_pkg::LeafBit];
                  rsp_index_error_in = !node[opl_pkg::LeafBit] && !at_bottom;
                  rsp_cell_size_in   = opl_pkg::CellW'(size_ff);
                  rsp_box_min_x_in   = min_x_ff;
                  rsp_box_min_y_in   = min_y_ff;
                  rsp_box_min_z_in   = min_z_ff;
                  rsp_level_in       = opl_pkg::LvlW'(depth_ff);
                  state_in           = ST_IDLE;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               // descend into the octant
               ram_rd_en   = 1'b1;
               ram_rd_addr = child_idx[AW-1:0];
               size_in     = half;
               min_x_in    = min_x_ff + (bx ? opl_pkg::PosW'(half) : '0);
               min_y_in    = min_y_ff + (by ? opl_pkg::PosW'(half) : '0);
               min_z_in    = min_z_ff + (bz ? opl_pkg::PosW'(half) : '0);
               x_in        = x_ff << 1;
               y_in        = y_ff << 1;
               z_in        = z_ff << 1;
               depth_in    = depth_ff + DW'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_leaf_value_in  = node_ff[opl_pkg::ValW-1:0];
               rsp_is_leaf_in     = node_ff[opl_pkg::LeafBit];
               rsp_index_error_in = err_ff;
               rsp_cell_size_in   = opl_pkg::CellW'(size_ff);
               rsp_box_min_x_in   = min_x_ff;
               rsp_box_min_y_in   = min_y_ff;
               rsp_box_min_z_in   = min_z_ff;
               rsp_level_in       = opl_pkg::LvlW'(depth_ff);
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff               <= x_in;
      y_ff               <= y_in;
      z_ff               <= z_in;
      size_ff            <= size_in;
      depth_ff           <= depth_in;
      min_x_ff           <= min_x_in;
      min_y_ff           <= min_y_in;
      min_z_ff           <= min_z_in;
      node_ff            <= node_in;
      err_ff             <= err_in;
      rsp_leaf_value_ff  <= rsp_leaf_value_in;
      rsp_is_leaf_ff     <= rsp_is_leaf_in;
      rsp_index_error_ff <= rsp_index_error_in;
      rsp_cell_size_ff   <= rsp_cell_size_in;
      rsp_box_min_x_ff   <= rsp_box_min_x_in;
      rsp_box_min_y_ff   <= rsp_box_min_y_in;
      rsp_box_min_z_ff   <= rsp_box_min_z_in;
      rsp_level_ff       <= rsp_level_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_leaf_value  = rsp_leaf_value_ff;
   assign rsp_is_leaf     = rsp_is_leaf_ff;
   assign rsp_index_error = rsp_index_error_ff;
   assign rsp_cell_size   = rsp_cell_size_ff;
   assign rsp_box_min_x   = rsp_box_min_x_ff;
   assign rsp_box_min_y   = rsp_box_min_y_ff;
   assign rsp_box_min_z   = rsp_box_min_z_ff;
   assign rsp_level       = rsp_level_ff;

   assign query_take  = (state_ff == ST_IDLE) && req_valid && (req_op == opl_pkg::OP_LOCATE);
   assign write_quiet = (state_ff == ST_IDLE) && req_valid && (req_op == opl_pkg::OP_WRITE)
                        && !rsp_valid_ff;
   assign walking     = (state_ff == ST_WALK);
   assign size_want   = (SW'(1) << LEVELS) >> depth_ff;
   assign inner_done  = rsp_valid_ff && !rsp_is_leaf_ff && !rsp_index_error_ff;

   `OPL_ASSERT_NEXT(a_query_walks, query_take, walking, "query did not start a walk")
   `OPL_ASSERT_NEXT(a_write_silent, write_quiet, !rsp_valid_ff, "write produced a response")
   `OPL_ASSERT_IMPL(a_depth_bound, walking, depth_ff <= DW'(LEVELS), "walk past bottom level")
   `OPL_ASSERT_IMPL(a_size_track, walking, size_ff == size_want, "cell size out of step")
   `OPL_ASSERT_IMPL(a_inner_full, inner_done, rsp_level_ff == LvlBottom, "inner node above bottom")

endmodule

### bench/octree_locate_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octree locate checker
// Watches both channels of the octree point locate block. Keeps its own copy
// of the node table from accepted write requests and walks it for every
// accepted locate request. Each response is matched field by field against
// the oldest predicted cell.
// ----------------------------------------------------------------------------
module octree_locate_checker #(
   parameter int LEVELS      = 10,
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic                       req_op,
   input  logic [opl_pkg::IdxW-1:0]   req_table_index,
   input  logic [opl_pkg::WordW-1:0]  req_table_word,
   input  logic [opl_pkg::PosW-1:0]   req_pos_x,
   input  logic [opl_pkg::PosW-1:0]   req_pos_y,
   input  logic [opl_pkg::PosW-1:0]   req_pos_z,

   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [opl_pkg::ValW-1:0]   rsp_leaf_value,
   input  logic                       rsp_is_leaf,
   input  logic                       rsp_index_error,
   input  logic [opl_pkg::CellW-1:0]  rsp_cell_size,
   input  logic [opl_pkg::PosW-1:0]   rsp_box_min_x,
   input  logic [opl_pkg::PosW-1:0]   rsp_box_min_y,
   input  logic [opl_pkg::PosW-1:0]   rsp_box_min_z,
   input  logic [opl_pkg::LvlW-1:0]   rsp_level,

   output int                         mismatch_count,
   output int                         expected_count
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = opl_pkg::WordW + 1;

   typedef struct {
      logic [opl_pkg::ValW-1:0]   leaf_value;
      logic                       is_leaf;
      logic                       index_error;
      logic [opl_pkg::CellW-1:0]  cell_size;
      logic [opl_pkg::PosW-1:0]   min_x;
      logic [opl_pkg::PosW-1:0]   min_y;
      logic [opl_pkg::PosW-1:0]   min_z;
      logic [opl_pkg::LvlW-1:0]   level;
   } cell_result_type;

   logic [opl_pkg::WordW-1:0] node_table [TABLE_DEPTH];

   // ring of open predictions; the block holds at most two at a time
   cell_result_type cell_q [8];
   logic [2:0]      q_head;
   logic [2:0]      q_tail;
   int              q_count;

   function automatic cell_result_type locate_cell(input logic [opl_pkg::PosW-1:0] px,
                                                   input logic [opl_pkg::PosW-1:0] py,
                                                   input logic [opl_pkg::PosW-1:0] pz);
      cell_result_type           res;
      logic [opl_pkg::WordW-1:0] node;
      logic [CW-1:0]             child;
      logic [2:0]                octant;
      logic                      bx, by, bz;
      bit                        bad;
      int                        depth, sh, edge_len, mx, my, mz;
      node     = node_table[0];
      depth    = 0;
      edge_len = 1 << LEVELS;
      mx       = 0;
      my       = 0;
      mz       = 0;
      bad      = 1'b0;
      while (!node[opl_pkg::LeafBit] && depth < LEVELS && !bad) begin
         sh = LEVELS - 1 - depth;
         // coordinate bits above the port width read as zero
         bx = (sh < opl_pkg::PosW) ? px[sh] : 1'b0;
         by = (sh < opl_pkg::PosW) ? py[sh] : 1'b0;
         bz = (sh < opl_pkg::PosW) ? pz[sh] : 1'b0;
         octant = {bz, by, bx};
         child  = {2'b00, node[opl_pkg::ValW-1:0]} + CW'(octant);
         if (child >= CW'(TABLE_DEPTH)) begin
            // stop on the parent; this descent does not count
            bad = 1'b1;
         end else begin
            edge_len = edge_len >> 1;
            if (bx) mx += edge_len;
            if (by) my += edge_len;
            if (bz) mz += edge_len;
            depth++;
            node = node_table[child[AW-1:0]];
         end
      end
      res.leaf_value  = node[opl_pkg::ValW-1:0];
      res.is_leaf     = node[opl_pkg::LeafBit];
      res.index_error = bad;
      res.cell_size   = edge_len[opl_pkg::CellW-1:0];
      res.min_x       = mx[opl_pkg::PosW-1:0];
      res.min_y       = my[opl_pkg::PosW-1:0];
      res.min_z       = mz[opl_pkg::PosW-1:0];
      res.level       = depth[opl_pkg::LvlW-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < 200)
         $display("%0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      cell_result_type want;
      if (reset) begin
         q_head  = '0;
         q_tail  = '0;
         q_count = 0;
         expected_count <= 0;
      end else begin
         // retire the oldest prediction first; a request taken this cycle is newer
         if (rsp_valid && !rsp_stall) begin
            if (q_count == 0) begin
               report_mismatch("response with no open query", 32'd1, 32'd0);
            end else begin
               want    = cell_q[q_head];
               q_head  = q_head + 3'd1;
               q_count = q_count - 1;
               if (rsp_leaf_value !== want.leaf_value)
                  report_mismatch("leaf_value", 32'(rsp_leaf_value), 32'(want.leaf_value));
               if (rsp_is_leaf !== want.is_leaf)
                  report_mismatch("is_leaf", 32'(rsp_is_leaf), 32'(want.is_leaf));
               if (rsp_index_error !== want.index_error)
                  report_mismatch("index_error", 32'(rsp_index_error),
                                  32'(want.index_error));
               if (rsp_cell_size !== want.cell_size)
                  report_mismatch("cell_size", 32'(rsp_cell_size), 32'(want.cell_size));
               if (rsp_box_min_x !== want.min_x)
                  report_mismatch("box_min_x", 32'(rsp_box_min_x), 32'(want.min_x));
               if (rsp_box_min_y !== want.min_y)
                  report_mismatch("box_min_y", 32'(rsp_box_min_y), 32'(want.min_y));
               if (rsp_box_min_z !== want.min_z)
                  report_mismatch("box_min_z", 32'(rsp_box_min_z), 32'(want.min_z));
               if (rsp_level !== want.level)
                  report_mismatch("level", 32'(rsp_level), 32'(want.level));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_op == opl_pkg::OP_LOCATE) begin
               if (q_count == 8) begin
                  report_mismatch("open queries overflow", 32'(q_count), 32'd7);
               end else begin
                  cell_q[q_tail] = locate_cell(req_pos_x, req_pos_y, req_pos_z);
                  q_tail         = q_tail + 3'd1;
                  q_count        = q_count + 1;
               end
            end else if (32'(req_table_index) < 32'(TABLE_DEPTH)) begin
               node_table[AW'(req_table_index)] = req_table_word;
            end
         end
         expected_count <= q_count;
      end
   end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octree point locate testbench
// Builds octrees through write requests and queries points against them.
// Before each query the walk is traced on a shadow table and any entry it
// would read unwritten is filled first, so trees grow with random content.
// Both channels idle in random bursts; the checker judges every response.
// ----------------------------------------------------------------------------
module testbench;

   localparam int LEVELS      = 10;
   localparam int TABLE_DEPTH = 1024;
   localparam int AW          = $clog2(TABLE_DEPTH);
   localparam int CW          = opl_pkg::WordW + 1;
   localparam int ITEMS       = 950;
   localparam int QUIET_TAIL  = 120;
   localparam int TAIL_CYCLES = 40;
   localparam int STUCK_LIMIT = 2000;

   logic                       clock;
   logic                       reset;

   logic                       req_valid;
   logic                       req_stall;
   logic                       req_op;
   logic [opl_pkg::IdxW-1:0]   req_table_index;
   logic [opl_pkg::WordW-1:0]  req_table_word;
   logic [opl_pkg::PosW-1:0]   req_pos_x;
   logic [opl_pkg::PosW-1:0]   req_pos_y;
   logic [opl_pkg::PosW-1:0]   req_pos_z;

   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [opl_pkg::ValW-1:0]   rsp_leaf_value;
   logic                       rsp_is_leaf;
   logic                       rsp_index_error;
   logic [opl_pkg::CellW-1:0]  rsp_cell_size;
   logic [opl_pkg::PosW-1:0]   rsp_box_min_x;
   logic [opl_pkg::PosW-1:0]   rsp_box_min_y;
   logic [opl_pkg::PosW-1:0]   rsp_box_min_z;
   logic [opl_pkg::LvlW-1:0]   rsp_level;

   int                         mismatch_count;
   int                         expected_count;

   logic [opl_pkg::WordW-1:0]  shadow_table [TABLE_DEPTH];
   bit                         shadow_written [TABLE_DEPTH];

   int                         sent_count;
   bit                         quiet;
   int                         leaf_pct;
   int                         idle_pct;
   int unsigned                stall_left;
   int unsigned                free_left;
   int unsigned                stuck_cycles;

   octree_point_locate #(
      .LEVELS      (LEVELS),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dut (.*);

   octree_locate_checker #(
      .LEVELS      (LEVELS),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side: random stall bursts between free stretches
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (free_left != 0) begin
         rsp_stall <= 1'b0;
         free_left <= free_left - 1;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left <= $urandom_range(18, 1);
         free_left  <= $urandom_range(40, 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("[octree_point_locate] ERROR");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic sender_gap();
      if (!quiet && idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(18, 1)) @(posedge clock);
      end
   endtask

   // present one request and hold it until it is taken
   task automatic send_req(input opl_pkg::op_type op,
                           input logic [opl_pkg::IdxW-1:0] idx,
                           input logic [opl_pkg::WordW-1:0] word,
                           input logic [opl_pkg::PosW-1:0] px,
                           input logic [opl_pkg::PosW-1:0] py,
                           input logic [opl_pkg::PosW-1:0] pz);
      req_valid       <= 1'b1;
      req_op          <= op;
      req_table_index <= idx;
      req_table_word  <= word;
      req_pos_x       <= px;
      req_pos_y       <= py;
      req_pos_z       <= pz;
      do @(posedge clock); while (req_stall);
      sent_count++;
      quiet = (sent_count >= ITEMS - QUIET_TAIL);
      sender_gap();
   endtask

   task automatic write_word(input int idx, input logic [opl_pkg::WordW-1:0] word);
      shadow_table[AW'(idx)]   = word;
      shadow_written[AW'(idx)] = 1'b1;
      send_req(opl_pkg::OP_WRITE, opl_pkg::IdxW'(idx), word, opl_pkg::PosW'($urandom()),
               opl_pkg::PosW'($urandom()), opl_pkg::PosW'($urandom()));
   endtask

   // wait out every open query
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_count != 0);
   endtask

   function automatic logic [opl_pkg::WordW-1:0] node_word();
      int unsigned pick;
      pick = $urandom_range(99, 0);
      if (pick < leaf_pct) return {1'b1, 31'($urandom())};
      pick = $urandom_range(99, 0);
      if (pick < 88) return opl_pkg::WordW'($urandom_range(TABLE_DEPTH - 8, 0));
      // children that run off the end of the table
      if (pick < 96)
         return opl_pkg::WordW'($urandom_range(TABLE_DEPTH - 1, TABLE_DEPTH - 7));
      return {1'b0, 31'($urandom())};
   endfunction

   // first entry the walk would read before it was written, or -1
   function automatic int first_unwritten(input logic [opl_pkg::PosW-1:0] px,
                                          input logic [opl_pkg::PosW-1:0] py,
                                          input logic [opl_pkg::PosW-1:0] pz);
      logic [opl_pkg::WordW-1:0] node;
      logic [CW-1:0]             child;
      logic [2:0]                octant;
      int                        depth, sh;
      if (!shadow_written[0]) return 0;
      node = shadow_table[0];
      for (depth = 0; depth < LEVELS && !node[opl_pkg::LeafBit]; depth++) begin
         sh     = LEVELS - 1 - depth;
         octant = (sh < opl_pkg::PosW) ? {pz[sh], py[sh], px[sh]} : 3'b000;
         child  = {2'b00, node[opl_pkg::ValW-1:0]} + CW'(octant);
         if (child >= CW'(TABLE_DEPTH)) return -1;
         if (!shadow_written[child[AW-1:0]]) return int'(child);
         node = shadow_table[child[AW-1:0]];
      end
      return -1;
   endfunction

   task automatic locate(input logic [opl_pkg::PosW-1:0] px,
                         input logic [opl_pkg::PosW-1:0] py,
                         input logic [opl_pkg::PosW-1:0] pz);
      int hole;
      hole = first_unwritten(px, py, pz);
      while (hole >= 0) begin
         write_word(hole, node_word());
         hole = first_unwritten(px, py, pz);
      end
      send_req(opl_pkg::OP_LOCATE, opl_pkg::IdxW'($urandom()), opl_pkg::WordW'($urandom()),
               px, py, pz);
   endtask

   function automatic logic [opl_pkg::PosW-1:0] rand_coord();
      int unsigned pick;
      pick = $urandom_range(99, 0);
      if (pick < 8) return '0;
      if (pick < 16) return '1;
      return opl_pkg::PosW'($urandom());
   endfunction

   initial begin
      int phase_end;
      int pick;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_op          <= opl_pkg::OP_WRITE;
      req_table_index <= '0;
      req_table_word  <= '0;
      req_pos_x       <= '0;
      req_pos_y       <= '0;
      req_pos_z       <= '0;
      leaf_pct        = 35;
      idle_pct        = 30;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // root is a leaf with the largest material: whole-space cell
      write_word(0, 32'hFFFF_FFFF);
      locate('0, '0, '0);
      locate('1, '1, '1);

      // root children at the table end: octants past the last entry fail
      write_word(0, opl_pkg::WordW'(TABLE_DEPTH - 4));
      write_word(TABLE_DEPTH - 4, 32'h8000_0000);
      for (int i = TABLE_DEPTH - 3; i < TABLE_DEPTH; i++)
         write_word(i, {1'b1, 31'($urandom())});
      locate('0, '0, '0);
      locate('0, '0, '1);
      locate('1, '1, '1);

      // self-referencing nodes: walk runs the full depth without a leaf
      for (int i = 8; i < 16; i++)
         write_word(i, 32'h0000_0008);
      write_word(0, 32'h0000_0008);
      locate('1, '1, '1);
      locate('0, '0, '0);
      locate(10'h2AA, 10'h155, 10'h3F0);
      drain_results();

      while (sent_count < ITEMS) begin
         case ($urandom_range(2, 0))
            0: leaf_pct = 10;
            1: leaf_pct = 35;
            default: leaf_pct = 65;
         endcase
         case ($urandom_range(2, 0))
            0: idle_pct = 0;
            1: idle_pct = 20;
            default: idle_pct = 50;
         endcase
         phase_end = sent_count + $urandom_range(140, 60);
         while (sent_count < phase_end && sent_count < ITEMS) begin
            pick = $urandom_range(99, 0);
            if (pick < 70)
               locate(rand_coord(), rand_coord(), rand_coord());
            else if (pick < 90)
               write_word($urandom_range(TABLE_DEPTH - 1, 0), node_word());
            else
               write_word(0, node_word());
         end
         drain_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[octree_point_locate] OK");
      else
         $display("[octree_point_locate] ERROR");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/opl_pkg.sv
rtl/opl_ram.sv
rtl/octree_point_locate.sv
bench/octree_locate_checker.sv
bench/testbench.sv
